FILE: src/fit_policy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fit-policy block allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define FPBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence starting in the cycle after its trigger
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types, codes and default sizes shared by the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Default sizing of the free-size table
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 24;

  // Fixed field widths of the words on the ports
  localparam int AMOUNT_W   = 24;
  localparam int BLK_W      = 4;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int CELL_CNT_W = 9;

  // Reset value of block_count
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(16);

  // Fit policy codes (the unused code behaves as first fit)
  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Input word modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [BLK_W-1:0]    block_index;
    logic [AMOUNT_W-1:0] amount;
    logic                last_request;
  } in_word_t;

  typedef struct packed {
    logic                granted;
    logic [BLK_W-1:0]    chosen_block;
    logic [AMOUNT_W-1:0] remaining;
    logic                last_result;
  } out_word_t;

  // Control part of the search token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

FILE: src/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// First, best and worst fit allocator over a chain of free-size cells.
// ----------------------------------------------------------------------------
// A load word writes one block's free size; it gives no result. A request
// word launches a search token into a chain of MAX_BLOCKS cells, one cell per
// cycle, each cell offering its entry under the selected fit policy; the
// token leaving the last cell writes the reduced size back on a grant and
// forms the result. A request keeps in_ready low from its launch register
// through the walk down the chain to the write-back. Two finished results
// can be held against a stalled output; while both are held, in_ready stays
// low. Table entries come up undefined and must be loaded before a request
// scans them; the user must write configuration only while the block is
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CELL_CNT_W-1:0] DEPTH = CELL_CNT_W'(MAX_BLOCKS);

  // configuration registers
  logic [POLICY_W-1:0] fit_policy_r;
  logic [COUNT_W-1:0]  block_count_r;

  // request bookkeeping
  logic                busy_r, busy_nxt;
  logic                start_r, start_nxt;
  logic [SIZE_WIDTH-1:0] req_amount_r;
  logic                req_last_r;

  // result buffering
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  out_word_t           pend_word_r, pend_word_nxt;

  // cell chain
  tok_ctl_t              tok_ctl  [0:MAX_BLOCKS];
  logic [SIZE_WIDTH-1:0] tok_size [0:MAX_BLOCKS];
  logic [IDX_W-1:0]      tok_idx  [0:MAX_BLOCKS];

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [SIZE_WIDTH-1:0] wr_data;

  logic                  in_fire;
  logic                  req_fire;
  logic                  load_fire;
  logic                  load_ok;
  logic                  done;
  logic [SIZE_WIDTH-1:0] rem_size;
  out_word_t             res_word;
  logic                  out_free;

  // Accept words only between requests and while a result slot is free
  assign in_ready  = !busy_r && !pend_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign req_fire  = in_fire && (in_data.mode == MODE_REQUEST);
  assign load_fire = in_fire && (in_data.mode == MODE_LOAD);
  assign load_ok   = (CELL_CNT_W'(in_data.block_index) < DEPTH);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r  <= FIT_FIRST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:  fit_policy_r  <= POLICY_W'(cfg_data);
        CFG_BLOCK_COUNT: block_count_r <= COUNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Final token of the chain closes the request
  assign done     = tok_ctl[MAX_BLOCKS].valid;
  assign rem_size = tok_size[MAX_BLOCKS] - req_amount_r;

  always_comb begin
    res_word.granted      = tok_ctl[MAX_BLOCKS].found;
    res_word.chosen_block = tok_ctl[MAX_BLOCKS].found ? BLK_W'(tok_idx[MAX_BLOCKS]) : '0;
    res_word.remaining    = tok_ctl[MAX_BLOCKS].found ? AMOUNT_W'(rem_size) : '0;
    res_word.last_result  = req_last_r;
  end

  // Drive the shared entry write: a load, or the write-back of a grant
  always_comb begin
    if (done) begin
      wr_en   = tok_ctl[MAX_BLOCKS].found;
      wr_idx  = tok_idx[MAX_BLOCKS];
      wr_data = rem_size;
    end else begin
      wr_en   = load_fire && load_ok;
      wr_idx  = IDX_W'(in_data.block_index);
      wr_data = SIZE_WIDTH'(in_data.amount);
    end
  end

  // Track the request in flight
  always_comb begin
    busy_nxt  = busy_r;
    start_nxt = req_fire;
    if (req_fire) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      start_r <= start_nxt;
    end
  end

  // Hold the request amount and batch mark for the whole walk
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_amount_r <= SIZE_WIDTH'(in_data.amount);
      req_last_r   <= in_data.last_request;
    end
  end

  // Launch an empty token into the first cell
  assign tok_ctl[0].valid = start_r;
  assign tok_ctl[0].found = 1'b0;
  assign tok_size[0]      = '0;
  assign tok_idx[0]       = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .CELL_INDEX (g),
      .IDX_W      (IDX_W),
      .SIZE_W     (SIZE_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .policy       (fit_policy_r),
      .block_count  (block_count_r),
      .req_amount   (req_amount_r),
      .wr_en        (wr_en),
      .wr_idx       (wr_idx),
      .wr_data      (wr_data),
      .tok_in_ctl   (tok_ctl[g]),
      .tok_in_size  (tok_size[g]),
      .tok_in_idx   (tok_idx[g]),
      .tok_out_ctl  (tok_ctl[g+1]),
      .tok_out_size (tok_size[g+1]),
      .tok_out_idx  (tok_idx[g+1])
    );
  end

  // Buffer results: output register plus one pending slot
  always_comb begin
    out_free       = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    pend_valid_nxt = pend_valid_r;
    pend_word_nxt  = pend_word_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = pend_word_r;
        if (done) begin
          pend_word_nxt = res_word;
        end else begin
          pend_valid_nxt = 1'b0;
        end
      end else if (done) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = res_word;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (done) begin
      pend_valid_nxt = 1'b1;
      pend_word_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    pend_word_r <= pend_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: src/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry: holds a block's free size and updates the passing search
// token with its own candidacy before handing it to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell import fpba_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 4,
  parameter int SIZE_W     = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // broadcast controls
  input  logic [POLICY_W-1:0]   policy,
  input  logic [COUNT_W-1:0]    block_count,
  input  logic [SIZE_W-1:0]     req_amount,
  // entry write (load or write-back)
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [SIZE_W-1:0]     wr_data,
  // token from the previous cell
  input  tok_ctl_t              tok_in_ctl,
  input  logic [SIZE_W-1:0]     tok_in_size,
  input  logic [IDX_W-1:0]      tok_in_idx,
  // token to the next cell
  output tok_ctl_t              tok_out_ctl,
  output logic [SIZE_W-1:0]     tok_out_size,
  output logic [IDX_W-1:0]      tok_out_idx
);

  localparam logic [IDX_W-1:0]      MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [CELL_CNT_W-1:0] MY_POS = CELL_CNT_W'(CELL_INDEX);

  logic [SIZE_W-1:0] free_r;
  tok_ctl_t          ctl_r, ctl_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              active;
  logic              fits;
  logic              take;

  // Hold the entry; write on load or write-back
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      free_r <= wr_data;
    end
  end

  // Decide whether this entry beats the token's current pick
  always_comb begin
    active = (CELL_CNT_W'(block_count) > MY_POS);
    fits   = active && (free_r >= req_amount);
    take   = 1'b0;
    if (fits) begin
      if (!tok_in_ctl.found) begin
        take = 1'b1;
      end else begin
        case (policy)
          FIT_BEST:  take = (free_r < tok_in_size);
          FIT_WORST: take = (free_r > tok_in_size);
          default:   take = 1'b0;
        endcase
      end
    end
    ctl_nxt.valid = tok_in_ctl.valid;
    if (take) begin
      ctl_nxt.found = 1'b1;
      size_nxt      = free_r;
      idx_nxt       = MY_IDX;
    end else begin
      ctl_nxt.found = tok_in_ctl.found;
      size_nxt      = tok_in_size;
      idx_nxt       = tok_in_idx;
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    idx_r  <= idx_nxt;
  end

  assign tok_out_ctl  = ctl_r;
  assign tok_out_size = size_r;
  assign tok_out_idx  = idx_r;

endmodule

FILE: src/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks on the fit-policy block allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_defines.svh"

module fpba_checker import fpba_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled result word holds
  `FPBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // A refused allocation reports block zero and nothing remaining
  `FPBA_ASSERT_SAME(a_refused_zero, out_valid && !out_data.granted, (out_data.chosen_block == '0) && (out_data.remaining == '0), "refused result carries a block or size")

  // An accepted request blocks the input as its walk begins
  `FPBA_ASSERT_NEXT(a_req_busy, in_valid && in_ready && (in_data.mode == MODE_REQUEST), !in_ready ##1 !in_ready, "input accepted during a request scan")

  // A load never produces a result on its own
  `FPBA_ASSERT_NEXT(a_load_silent, !out_valid && in_valid && in_ready && (in_data.mode == MODE_LOAD), !out_valid, "result appeared after a load")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);
